[src/tcmec_pkg.sv]
// ----------------------------------------------------------------------------
// tcmec_pkg
// Shared types and constants of the service mode controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcmec_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_FRAME = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    // Recording action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_DISABLE = 2'd1;
    localparam logic [1:0] ACT_ENABLE  = 2'd2;

    // Mode request codes
    localparam logic [1:0] CODE_LEAVE = 2'd0;
    localparam logic [1:0] CODE_ENTER = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_REQUEST_WINDOW = 2'd0;
    localparam logic [1:0] CFG_CLEAR_WINDOW   = 2'd1;
    localparam logic [1:0] CFG_EXIT_HOLD_TIME = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_REQUEST_WINDOW = 8'd100;
    localparam logic [7:0] RST_CLEAR_WINDOW   = 8'd100;
    localparam logic [7:0] RST_EXIT_HOLD_TIME = 8'd50;

    localparam logic [7:0] CNT_MAX     = 8'd255;
    localparam logic [7:0] CONFIRM_CNT = 8'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic       engine_running;
        logic       diag_active;
        logic       main_wakeup;
        logic       wake_signal;
        logic [7:0] vehicle_speed;
        logic       clear_request;
        logic       request_low_bit;
        logic       request_high_bit;
        logic [7:0] wake_count;
        logic       soft_reset;
    } t_item;

    typedef struct packed {
        logic       mode_active;
        logic [1:0] record_action;
        logic       clear_all_faults;
    } t_result;

    typedef struct packed {
        logic [7:0] request_window;
        logic [7:0] clear_window;
        logic [7:0] exit_hold_time;
    } t_cfg;

    // Saturating decrement towards zero
    function automatic logic [7:0] f_dec_sat(input logic [7:0] v);
        return (v != 8'd0) ? 8'(v - 8'd1) : 8'd0;
    endfunction

    // Saturating increment towards CNT_MAX
    function automatic logic [7:0] f_inc_sat(input logic [7:0] v);
        return (v != CNT_MAX) ? 8'(v + 8'd1) : CNT_MAX;
    endfunction

endpackage

`default_nettype wire

[src/tcmec_cfg.sv]
// ----------------------------------------------------------------------------
// tcmec_cfg
// Configuration registers, written over their own valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcmec_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    output tcmec_pkg::t_cfg      o_cfg
);

    tcmec_pkg::t_cfg r_cfg;

    // A transfer is taken every cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_window <= tcmec_pkg::RST_REQUEST_WINDOW;
            r_cfg.clear_window   <= tcmec_pkg::RST_CLEAR_WINDOW;
            r_cfg.exit_hold_time <= tcmec_pkg::RST_EXIT_HOLD_TIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcmec_pkg::CFG_REQUEST_WINDOW: r_cfg.request_window <= i_cfg_data;
                tcmec_pkg::CFG_CLEAR_WINDOW:   r_cfg.clear_window   <= i_cfg_data;
                tcmec_pkg::CFG_EXIT_HOLD_TIME: r_cfg.exit_hold_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/tcmec_in_stage.sv]
// ----------------------------------------------------------------------------
// tcmec_in_stage
// Input register: holds one accepted item until the step logic takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcmec_in_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire tcmec_pkg::t_item i_item,
    input  wire logic             i_advance,
    output logic                  o_ready,
    output logic                  o_valid,
    output tcmec_pkg::t_item      o_item
);

    logic             r_valid;
    tcmec_pkg::t_item r_item;

    // Free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[src/tcmec_step.sv]
// ----------------------------------------------------------------------------
// tcmec_step
// Controller state and the per-item update: timers, confirmation counts,
// mode entry and exit, fault clear pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcmec_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire tcmec_pkg::t_item i_item,
    input  wire tcmec_pkg::t_cfg  i_cfg,
    output tcmec_pkg::t_result    o_result
);

    logic       r_mode_on,         n_mode_on;
    logic       r_saved_marker,    n_saved_marker;
    logic [7:0] r_post_reset_wait, n_post_reset_wait;
    logic [7:0] r_request_timer,   n_request_timer;
    logic [7:0] r_clear_timer,     n_clear_timer;
    logic [7:0] r_exit_hold_timer, n_exit_hold_timer;
    logic [7:0] r_request_count,   n_request_count;
    logic [7:0] r_clear_count,     n_clear_count;
    logic [1:0] r_last_code,       n_last_code;

    logic [1:0] action;
    logic       clear_pulse;

    // Next state for the item in the input register
    always_comb begin
        logic [1:0] code;
        logic       safe;
        logic       leave;
        logic       enter;

        code  = {i_item.request_high_bit, i_item.request_low_bit};
        safe  = !i_item.engine_running && (i_item.vehicle_speed == 8'd0) &&
                i_item.main_wakeup && i_item.wake_signal && !i_item.diag_active;
        leave = 1'b0;
        enter = 1'b0;

        n_mode_on         = r_mode_on;
        n_saved_marker    = r_saved_marker;
        n_post_reset_wait = r_post_reset_wait;
        n_request_timer   = r_request_timer;
        n_clear_timer     = r_clear_timer;
        n_exit_hold_timer = r_exit_hold_timer;
        n_request_count   = r_request_count;
        n_clear_count     = r_clear_count;
        n_last_code       = r_last_code;
        action            = tcmec_pkg::ACT_NONE;
        clear_pulse       = 1'b0;

        case (i_item.cmd)
            tcmec_pkg::CMD_INIT: begin
                if (i_item.wake_count != tcmec_pkg::CNT_MAX) begin
                    n_post_reset_wait = 8'(i_item.wake_count + 8'd1);
                end
                n_exit_hold_timer = 8'd0;
                n_request_timer   = 8'd0;
                n_clear_timer     = 8'd0;
                n_request_count   = 8'd0;
                n_clear_count     = 8'd0;
                // Restore only after a software reset with the marker set
                if (i_item.soft_reset && r_saved_marker) begin
                    n_mode_on = 1'b1;
                    action    = tcmec_pkg::ACT_DISABLE;
                end else begin
                    n_mode_on = 1'b0;
                    action    = tcmec_pkg::ACT_ENABLE;
                end
            end

            tcmec_pkg::CMD_TICK: begin
                n_post_reset_wait = tcmec_pkg::f_dec_sat(r_post_reset_wait);
                n_clear_timer     = tcmec_pkg::f_dec_sat(r_clear_timer);
                n_request_timer   = tcmec_pkg::f_dec_sat(r_request_timer);
                n_exit_hold_timer = i_item.main_wakeup ? i_cfg.exit_hold_time
                                  : tcmec_pkg::f_dec_sat(r_exit_hold_timer);
                // Safety exit, judged on the updated timers
                if (r_mode_on && (i_item.engine_running ||
                                  (i_item.vehicle_speed != 8'd0) ||
                                  i_item.diag_active || !i_item.wake_signal ||
                                  (!i_item.main_wakeup &&
                                   (n_post_reset_wait == 8'd0) &&
                                   (n_exit_hold_timer == 8'd0)))) begin
                    leave = 1'b1;
                end
            end

            tcmec_pkg::CMD_FRAME: begin
                if (safe) begin
                    // Mode request confirmation
                    if (r_request_timer == 8'd0) begin
                        n_request_count = 8'd1;
                        n_request_timer = i_cfg.request_window;
                    end else begin
                        n_request_count = tcmec_pkg::f_inc_sat(r_request_count);
                    end
                    if (n_request_count == 8'd1) begin
                        n_last_code = code;
                    end else if (r_last_code != code) begin
                        n_last_code     = code;
                        n_request_count = 8'd1;
                        n_request_timer = i_cfg.request_window;
                    end else if (n_request_count == tcmec_pkg::CONFIRM_CNT) begin
                        if (code == tcmec_pkg::CODE_ENTER) begin
                            enter = 1'b1;
                        end else if (code == tcmec_pkg::CODE_LEAVE) begin
                            leave = 1'b1;
                        end
                        n_request_timer = 8'd0;
                    end
                    // Fault clear confirmation
                    if (i_item.clear_request) begin
                        if (r_clear_timer == 8'd0) begin
                            n_clear_count = 8'd1;
                            n_clear_timer = i_cfg.clear_window;
                        end else begin
                            n_clear_count = tcmec_pkg::f_inc_sat(r_clear_count);
                        end
                        clear_pulse = (n_clear_count >= tcmec_pkg::CONFIRM_CNT);
                    end else begin
                        n_clear_timer = 8'd0;
                    end
                end else if (i_item.main_wakeup || (r_exit_hold_timer == 8'd0)) begin
                    leave = 1'b1;
                end
            end

            default: ;
        endcase

        // Mode transitions
        if (enter) begin
            n_mode_on      = 1'b1;
            n_saved_marker = 1'b1;
            action         = tcmec_pkg::ACT_DISABLE;
        end
        if (leave) begin
            n_mode_on       = 1'b0;
            n_saved_marker  = 1'b0;
            n_request_count = 8'd0;
            action          = tcmec_pkg::ACT_ENABLE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_on         <= 1'b0;
            r_saved_marker    <= 1'b0;
            r_post_reset_wait <= 8'd0;
            r_request_timer   <= 8'd0;
            r_clear_timer     <= 8'd0;
            r_exit_hold_timer <= 8'd0;
            r_request_count   <= 8'd0;
            r_clear_count     <= 8'd0;
            r_last_code       <= 2'd0;
        end else if (i_en) begin
            r_mode_on         <= n_mode_on;
            r_saved_marker    <= n_saved_marker;
            r_post_reset_wait <= n_post_reset_wait;
            r_request_timer   <= n_request_timer;
            r_clear_timer     <= n_clear_timer;
            r_exit_hold_timer <= n_exit_hold_timer;
            r_request_count   <= n_request_count;
            r_clear_count     <= n_clear_count;
            r_last_code       <= n_last_code;
        end
    end

    assign o_result.mode_active      = n_mode_on;
    assign o_result.record_action    = action;
    assign o_result.clear_all_faults = clear_pulse;

endmodule

`default_nettype wire

[src/tcmec_out_stage.sv]
// ----------------------------------------------------------------------------
// tcmec_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcmec_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire tcmec_pkg::t_result i_result,
    input  wire logic               i_ready,
    output logic                    o_space,
    output logic                    o_valid,
    output tcmec_pkg::t_result      o_result
);

    logic               r_valid;
    tcmec_pkg::t_result r_result;

    // Room when empty or when the held result is taken this cycle
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/triple_confirm_mode_entry_controller.sv]
// ----------------------------------------------------------------------------
// triple_confirm_mode_entry_controller
// Service mode controller: entry/exit confirmed by three identical request
// codes, exit also when unsafe; fault clear confirmed by three clear requests.
//
// Usage:
// - Input channel i_valid/o_ready carries one item (tick, frame or init).
//   Each input item yields exactly one result on o_valid/i_ready.
// - Configuration channel i_cfg_valid/o_cfg_ready writes one 8-bit register
//   per transfer; it is always ready. Write only while the block is idle.
// - An accepted item waits in the input register; the step logic then
//   writes its result into the result register when that register has room.
// - Throughput: one item per cycle while the receiver does not stall, set
//   by the state update between the input and result registers.
// - When the receiver stalls, the result register holds and the input
//   register still takes one more item; after that o_ready drops.
// - Synchronous reset clears all mode state and timers, empties both
//   registers and loads the configuration defaults (100, 100, 50).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triple_confirm_mode_entry_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // Input items
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic       i_engine_running,
    input  wire logic       i_diag_active,
    input  wire logic       i_main_wakeup,
    input  wire logic       i_wake_signal,
    input  wire logic [7:0] i_vehicle_speed,
    input  wire logic       i_clear_request,
    input  wire logic       i_request_low_bit,
    input  wire logic       i_request_high_bit,
    input  wire logic [7:0] i_wake_count,
    input  wire logic       i_soft_reset,
    // Results
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_mode_active,
    output logic [1:0]      o_record_action,
    output logic            o_clear_all_faults
);

    tcmec_pkg::t_cfg    cfg;
    tcmec_pkg::t_item   in_item;
    tcmec_pkg::t_item   held_item;
    tcmec_pkg::t_result step_result;
    tcmec_pkg::t_result out_result;
    logic               held_valid;
    logic               out_space;
    logic               advance;

    assign o_cfg_ready = 1'b1;

    // Bundle the input fields
    assign in_item.cmd              = i_cmd;
    assign in_item.engine_running   = i_engine_running;
    assign in_item.diag_active      = i_diag_active;
    assign in_item.main_wakeup      = i_main_wakeup;
    assign in_item.wake_signal      = i_wake_signal;
    assign in_item.vehicle_speed    = i_vehicle_speed;
    assign in_item.clear_request    = i_clear_request;
    assign in_item.request_low_bit  = i_request_low_bit;
    assign in_item.request_high_bit = i_request_high_bit;
    assign in_item.wake_count       = i_wake_count;
    assign in_item.soft_reset       = i_soft_reset;

    // Held item is processed when the result register has room
    assign advance = held_valid && out_space;

    tcmec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcmec_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_ready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    tcmec_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    tcmec_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .i_ready  (i_ready),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_mode_active      = out_result.mode_active;
    assign o_record_action    = out_result.record_action;
    assign o_clear_all_faults = out_result.clear_all_faults;

endmodule

`default_nettype wire
